[rtl/crd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crd_pkg: shared constants for the camera ray direction block
// Widths of the fixed-point datapath and the configuration register indexes.
// ----------------------------------------------------------------------------
package crd_pkg;

  // Default geometry of the block.
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration port.
  localparam int REG_BITS  = 24;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;

  // Scale registers hold two extra bits so that a reset value of 1.0 fits
  // at every fraction width up to REG_BITS.
  localparam int SCALE_W = REG_BITS + 2;

  // Normalization datapath.
  localparam int NORM_LIMIT = 30;             // magnitudes are cut below 2^30
  localparam int M_W        = NORM_LIMIT;
  localparam int SQ1_W      = 2 * M_W;        // one square
  localparam int SQ_W       = SQ1_W + 2;      // sum of three squares
  localparam int ROOT_W     = SQ_W / 2;
  localparam int OUT_FRAC   = 15;
  localparam int QUOT_W     = OUT_FRAC + 1;   // quotient never exceeds 2^15
  localparam int NUM_W      = M_W + QUOT_W + 1;
  localparam int DEN_W      = ROOT_W + 1;
  localparam int LANES      = 3;

endpackage : crd_pkg
`default_nettype wire

[rtl/crd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crd_if: channel interfaces of the camera ray direction block
// Pixel requests in, direction results out, and configuration writes.
// ----------------------------------------------------------------------------
interface crd_pixel_if #(
  parameter int COORD_BITS = crd_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface : crd_pixel_if

interface crd_dir_if;
  logic                                valid;
  logic                                ready;
  logic signed [crd_pkg::OUT_FRAC:0]   dir_x;
  logic signed [crd_pkg::OUT_FRAC:0]   dir_y;
  logic        [crd_pkg::OUT_FRAC-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface : crd_dir_if

interface crd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crd_pkg::CFG_IDX_W-1:0]    index;
  logic [crd_pkg::REG_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : crd_cfg_if
`default_nettype wire

[rtl/camera_ray_direction.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// camera_ray_direction: pinhole camera ray direction generator
// Maps a pixel coordinate to a unit view direction in Q1.15.
// ----------------------------------------------------------------------------
// Usage:
// While ready is high, the pixel channel takes one request (pixel_x, pixel_y)
// per cycle. Each request gives exactly one result on the dir channel, in
// request order: dir_x and dir_y signed Q1.15 and dir_z unsigned Q0.15,
// all saturated. The cfg channel writes scale_x, offset_x, scale_y and
// offset_y (Q8.16) by index; it is always ready, and writes to unknown
// indexes are dropped. Write configuration only while no request is in
// flight. The path from request to result is the same at any COORD_BITS:
// the affine map, magnitude and scaling stages, the 31-stage square root
// with one root bit per stage, a setup stage, the 16-stage divider with
// one quotient bit per stage, a saturation stage and the output register.
// Throughput is one request per cycle while the skid register is empty.
// When the receiver stalls, the result waits in the output register, one
// more item lands in a skid register, and then the whole pipeline holds
// until the receiver takes a result again. Reset clears all valid bits and
// loads scale_x = 1.0, scale_y = -1.0 and zero offsets.
// ----------------------------------------------------------------------------
module camera_ray_direction #(
  parameter int COORD_BITS = crd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = crd_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  crd_pixel_if.sink  pixel,
  crd_dir_if.source  dir,
  crd_cfg_if.sink    cfg
);
  import crd_pkg::*;

  localparam int PW   = COORD_BITS + SCALE_W + 1;  // signed product and sum
  localparam int MW   = COORD_BITS + REG_BITS;     // component magnitude
  localparam int MAXS = MW - NORM_LIMIT;           // largest shift needed
  localparam int SW   = $clog2(MAXS + 1);
  localparam logic signed [SCALE_W-1:0] ONE = SCALE_W'(1) << FRAC_BITS;
  localparam logic [MW-1:0] MZ = MW'(1) << FRAC_BITS;
  localparam logic [QUOT_W-1:0] POS_MAX = {1'b0, {OUT_FRAC{1'b1}}};
  localparam logic [QUOT_W-1:0] NEG_MAX = {1'b1, {OUT_FRAC{1'b0}}};

  // Pipeline advance: the pipeline holds only while the skid register is full.
  logic en;

  // Configuration registers.
  logic signed [SCALE_W-1:0]  scale_x;
  logic signed [SCALE_W-1:0]  scale_y;
  logic signed [REG_BITS-1:0] offset_x;
  logic signed [REG_BITS-1:0] offset_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x  <= ONE;
      offset_x <= '0;
      scale_y  <= -ONE;
      offset_y <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCALE_X:  scale_x  <= SCALE_W'(signed'(cfg.data));
        REG_OFFSET_X: offset_x <= signed'(cfg.data);
        REG_SCALE_Y:  scale_y  <= SCALE_W'(signed'(cfg.data));
        REG_OFFSET_Y: offset_y <= signed'(cfg.data);
        default: ;
      endcase
    end
  end

  // Stage 1: scale the pixel coordinates.
  logic                 s1_v;
  logic signed [PW-1:0] s1_px;
  logic signed [PW-1:0] s1_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px <= PW'($signed({1'b0, pixel.pixel_x}) * scale_x);
      s1_py <= PW'($signed({1'b0, pixel.pixel_y}) * scale_y);
    end
  end

  // Stage 2: add the principal point terms.
  logic                 s2_v;
  logic signed [PW-1:0] s2_dx;
  logic signed [PW-1:0] s2_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dx <= s1_px + PW'(offset_x);
      s2_dy <= s1_py + PW'(offset_y);
    end
  end

  // Stage 3: split into sign and magnitude.
  logic          s3_v;
  logic [MW-1:0] s3_mx;
  logic [MW-1:0] s3_my;
  logic          s3_nx;
  logic          s3_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nx <= s2_dx[PW-1];
      s3_ny <= s2_dy[PW-1];
      s3_mx <= MW'(s2_dx[PW-1] ? -s2_dx : s2_dx);
      s3_my <= MW'(s2_dy[PW-1] ? -s2_dy : s2_dy);
    end
  end

  // Stage 4: largest of the three magnitudes.
  logic          s4_v;
  logic [MW-1:0] s4_mx;
  logic [MW-1:0] s4_my;
  logic          s4_nx;
  logic          s4_ny;
  logic [MW-1:0] s4_big;
  logic [MW-1:0] big_xy;
  logic [MW-1:0] big_all;

  assign big_xy  = (s3_mx > s3_my) ? s3_mx : s3_my;
  assign big_all = (big_xy > MZ) ? big_xy : MZ;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mx  <= s3_mx;
      s4_my  <= s3_my;
      s4_nx  <= s3_nx;
      s4_ny  <= s3_ny;
      s4_big <= big_all;
    end
  end

  // Stage 5: smallest right shift that brings the largest magnitude below 2^30.
  logic          s5_v;
  logic [MW-1:0] s5_mx;
  logic [MW-1:0] s5_my;
  logic          s5_nx;
  logic          s5_ny;
  logic [SW-1:0] s5_shift;
  logic [SW-1:0] shift;

  always_comb begin
    shift = SW'(MAXS);
    for (int k = MAXS; k >= 0; k--) begin
      if ((s4_big >> (NORM_LIMIT + k)) == '0) begin
        shift = SW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_mx    <= s4_mx;
      s5_my    <= s4_my;
      s5_nx    <= s4_nx;
      s5_ny    <= s4_ny;
      s5_shift <= shift;
    end
  end

  // Stage 6: apply the shift to all three components.
  logic           s6_v;
  logic [M_W-1:0] s6_mx;
  logic [M_W-1:0] s6_my;
  logic [M_W-1:0] s6_mz;
  logic           s6_nx;
  logic           s6_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_mx <= M_W'(s5_mx >> s5_shift);
      s6_my <= M_W'(s5_my >> s5_shift);
      s6_mz <= M_W'(MZ >> s5_shift);
      s6_nx <= s5_nx;
      s6_ny <= s5_ny;
    end
  end

  // Stage 7: squares.
  logic             s7_v;
  logic [M_W-1:0]   s7_mx;
  logic [M_W-1:0]   s7_my;
  logic [M_W-1:0]   s7_mz;
  logic             s7_nx;
  logic             s7_ny;
  logic [SQ1_W-1:0] s7_sx;
  logic [SQ1_W-1:0] s7_sy;
  logic [SQ1_W-1:0] s7_sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_mx <= s6_mx;
      s7_my <= s6_my;
      s7_mz <= s6_mz;
      s7_nx <= s6_nx;
      s7_ny <= s6_ny;
      s7_sx <= SQ1_W'(s6_mx) * SQ1_W'(s6_mx);
      s7_sy <= SQ1_W'(s6_my) * SQ1_W'(s6_my);
      s7_sz <= SQ1_W'(s6_mz) * SQ1_W'(s6_mz);
    end
  end

  // Stage 8: squared length.
  localparam int SIDE8_W = 3 * M_W + 2;

  logic            s8_v;
  logic [SIDE8_W-1:0] s8_side;
  logic [SQ_W-1:0] s8_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_side <= {s7_mx, s7_my, s7_mz, s7_nx, s7_ny};
      s8_sum  <= SQ_W'(s7_sx) + SQ_W'(s7_sy) + SQ_W'(s7_sz);
    end
  end

  // Square root of the squared length.
  logic               sq_v;
  logic [ROOT_W-1:0]  sq_len;
  logic [SIDE8_W-1:0] sq_side;

  crd_isqrt #(
    .IN_W   (SQ_W),
    .SIDE_W (SIDE8_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s8_v),
    .radicand  (s8_sum),
    .in_side   (s8_side),
    .out_valid (sq_v),
    .root      (sq_len),
    .out_side  (sq_side)
  );

  // Setup stage: numerators m * 2^16 + len over the divisor 2 * len.
  logic                        s9_v;
  logic [LANES-1:0][NUM_W-1:0] s9_num;
  logic [DEN_W-1:0]            s9_den;
  logic [2:0]                  s9_side;
  logic [M_W-1:0]              sq_mx;
  logic [M_W-1:0]              sq_my;
  logic [M_W-1:0]              sq_mz;
  logic                        sq_nx;
  logic                        sq_ny;

  assign {sq_mx, sq_my, sq_mz, sq_nx, sq_ny} = sq_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_num[0] <= NUM_W'({sq_mx, {QUOT_W{1'b0}}}) + NUM_W'(sq_len);
      s9_num[1] <= NUM_W'({sq_my, {QUOT_W{1'b0}}}) + NUM_W'(sq_len);
      s9_num[2] <= NUM_W'({sq_mz, {QUOT_W{1'b0}}}) + NUM_W'(sq_len);
      s9_den    <= {sq_len, 1'b0};
      s9_side   <= {sq_nx, sq_ny, (sq_len == '0)};
    end
  end

  // Division of each component by the doubled length.
  logic                         dv_v;
  logic [LANES-1:0][QUOT_W-1:0] dv_q;
  logic [2:0]                   dv_side;

  crd_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .QUOT_W (QUOT_W),
    .LANES  (LANES),
    .SIDE_W (3)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s9_v),
    .num       (s9_num),
    .den       (s9_den),
    .in_side   (s9_side),
    .out_valid (dv_v),
    .quot      (dv_q),
    .out_side  (dv_side)
  );

  // Saturation and sign.
  logic                       dv_nx;
  logic                       dv_ny;
  logic                       dv_zero;
  logic signed [QUOT_W-1:0]   sat_x;
  logic signed [QUOT_W-1:0]   sat_y;
  logic        [OUT_FRAC-1:0] sat_z;

  assign {dv_nx, dv_ny, dv_zero} = dv_side;

  always_comb begin
    logic [QUOT_W-1:0] qx;
    logic [QUOT_W-1:0] qy;
    if (dv_nx) begin
      qx = (dv_q[0] > NEG_MAX) ? NEG_MAX : dv_q[0];
      qx = -qx;
    end else begin
      qx = (dv_q[0] > POS_MAX) ? POS_MAX : dv_q[0];
    end
    if (dv_ny) begin
      qy = (dv_q[1] > NEG_MAX) ? NEG_MAX : dv_q[1];
      qy = -qy;
    end else begin
      qy = (dv_q[1] > POS_MAX) ? POS_MAX : dv_q[1];
    end
    sat_x = dv_zero ? '0 : signed'(qx);
    sat_y = dv_zero ? '0 : signed'(qy);
    sat_z = dv_zero ? '0 : OUT_FRAC'((dv_q[2] > POS_MAX) ? POS_MAX : dv_q[2]);
  end

  logic                       s10_v;
  logic signed [QUOT_W-1:0]   s10_x;
  logic signed [QUOT_W-1:0]   s10_y;
  logic        [OUT_FRAC-1:0] s10_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_x <= sat_x;
      s10_y <= sat_y;
      s10_z <= sat_z;
    end
  end

  // Output register with a skid register behind it.
  logic                       out_v;
  logic signed [QUOT_W-1:0]   out_x;
  logic signed [QUOT_W-1:0]   out_y;
  logic        [OUT_FRAC-1:0] out_z;
  logic                       skid_v;
  logic signed [QUOT_W-1:0]   skid_x;
  logic signed [QUOT_W-1:0]   skid_y;
  logic        [OUT_FRAC-1:0] skid_z;
  logic                       push;
  logic                       pop;

  assign en          = ~skid_v;
  assign pixel.ready = en;
  assign push        = en & s10_v;
  assign pop         = out_v & dir.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (!out_v || pop) begin
      out_v <= push;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        out_x <= skid_x;
        out_y <= skid_y;
        out_z <= skid_z;
      end
    end else if (!out_v || pop) begin
      out_x <= s10_x;
      out_y <= s10_y;
      out_z <= s10_z;
    end else begin
      skid_x <= s10_x;
      skid_y <= s10_y;
      skid_z <= s10_z;
    end
  end

  assign dir.valid = out_v;
  assign dir.dir_x = out_x;
  assign dir.dir_y = out_y;
  assign dir.dir_z = out_z;

endmodule : camera_ray_direction
`default_nettype wire

[rtl/crd_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crd_isqrt: pipelined integer square root
// One result bit per stage, digit-by-digit method, with side data alongside.
// ----------------------------------------------------------------------------
module crd_isqrt #(
  parameter int IN_W   = crd_pkg::SQ_W,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [IN_W-1:0]   radicand,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [IN_W/2-1:0]      root,
  output logic [SIDE_W-1:0]      out_side
);
  import crd_pkg::*;

  localparam int ITER = IN_W / 2;

  logic [IN_W-1:0]   rem_q  [ITER];
  logic [IN_W-1:0]   res_q  [ITER];
  logic              v_q    [ITER];
  logic [SIDE_W-1:0] side_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_step
    localparam int BP = IN_W - 2 - 2 * i;

    logic [IN_W-1:0]   rem_in;
    logic [IN_W-1:0]   res_in;
    logic              v_in;
    logic [SIDE_W-1:0] side_in;
    logic [IN_W:0]     trial;

    if (i == 0) begin : g_first
      assign rem_in  = radicand;
      assign res_in  = '0;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign res_in  = res_q[i-1];
      assign v_in    = v_q[i-1];
      assign side_in = side_q[i-1];
    end

    // Try to take the current bit; the sign of the difference decides.
    assign trial = {1'b0, rem_in} - ({1'b0, res_in} + ((IN_W+1)'(1) << BP));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i] <= side_in;
        if (!trial[IN_W]) begin
          rem_q[i] <= trial[IN_W-1:0];
          res_q[i] <= (res_in >> 1) + (IN_W'(1) << BP);
        end else begin
          rem_q[i] <= rem_in;
          res_q[i] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = v_q[ITER-1];
  assign root      = res_q[ITER-1][ITER-1:0];
  assign out_side  = side_q[ITER-1];

endmodule : crd_isqrt
`default_nettype wire

[rtl/crd_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crd_div: pipelined restoring divider, several numerators over one divisor
// One quotient bit per stage for every lane, side data carried alongside.
// ----------------------------------------------------------------------------
module crd_div #(
  parameter int NUM_W  = crd_pkg::NUM_W,
  parameter int DEN_W  = crd_pkg::DEN_W,
  parameter int QUOT_W = crd_pkg::QUOT_W,
  parameter int LANES  = crd_pkg::LANES,
  parameter int SIDE_W = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [LANES-1:0][NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]              den,
  input  wire logic [SIDE_W-1:0]             in_side,
  output logic                               out_valid,
  output logic [LANES-1:0][QUOT_W-1:0]       quot,
  output logic [SIDE_W-1:0]                  out_side
);
  import crd_pkg::*;

  logic [LANES-1:0][NUM_W-1:0]  rem_q  [QUOT_W];
  logic [LANES-1:0][QUOT_W-1:0] quo_q  [QUOT_W];
  logic [DEN_W-1:0]             den_q  [QUOT_W];
  logic                         v_q    [QUOT_W];
  logic [SIDE_W-1:0]            side_q [QUOT_W];

  for (genvar i = 0; i < QUOT_W; i++) begin : g_step
    localparam int BIT = QUOT_W - 1 - i;

    logic [LANES-1:0][NUM_W-1:0]  rem_in;
    logic [LANES-1:0][QUOT_W-1:0] quo_in;
    logic [DEN_W-1:0]             den_in;
    logic                         v_in;
    logic [SIDE_W-1:0]            side_in;
    logic [LANES-1:0][NUM_W-1:0]  rem_next;
    logic [LANES-1:0][QUOT_W-1:0] quo_next;
    logic [NUM_W-1:0]             den_sh;

    if (i == 0) begin : g_first
      assign rem_in  = num;
      assign quo_in  = '0;
      assign den_in  = den;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign den_in  = den_q[i-1];
      assign v_in    = v_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign den_sh = NUM_W'(den_in) << BIT;

    // Subtract the shifted divisor where it fits and set the quotient bit.
    always_comb begin
      logic [NUM_W:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial = {1'b0, rem_in[l]} - {1'b0, den_sh};
        if (!trial[NUM_W]) begin
          rem_next[l] = trial[NUM_W-1:0];
          quo_next[l] = quo_in[l] | (QUOT_W'(1) << BIT);
        end else begin
          rem_next[l] = rem_in[l];
          quo_next[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= rem_next;
        quo_q[i]  <= quo_next;
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign out_valid = v_q[QUOT_W-1];
  assign quot      = quo_q[QUOT_W-1];
  assign out_side  = side_q[QUOT_W-1];

endmodule : crd_div
`default_nettype wire
